// ----- sv/combination_wheel_pack_tracker_top_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the combination wheel pack tracker checker
// ---------------------------------------------------------------------------
`ifndef COMBINATION_WHEEL_PACK_TRACKER_TOP_ASSERT_SVH
`define COMBINATION_WHEEL_PACK_TRACKER_TOP_ASSERT_SVH

// Clocked assertion, muted while reset is high.
`define CWPT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define CWPT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/cwpt_pkg.sv -----
// ---------------------------------------------------------------------------
// cwpt_pkg
// Types and constants shared by the wheel pack tracker modules.
// ---------------------------------------------------------------------------
`default_nettype none

package cwpt_pkg;

  localparam int OP_W   = 2;
  localparam int TGT_W  = 7;
  localparam int DIR_W  = 2;
  localparam int POS_W  = 8;
  localparam int STEP_W = 14;
  localparam int MASK_W = 3;
  localparam int MSF_W  = 5;
  localparam int COEF_W = 12;
  localparam int PROD_W = COEF_W + MSF_W + 1;

  localparam logic [OP_W-1:0] OP_MOVE = 2'd0;
  localparam logic [OP_W-1:0] OP_TURN = 2'd1;
  localparam logic [OP_W-1:0] OP_ZERO = 2'd2;

  localparam logic [DIR_W-1:0] DIR_CW  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_CCW = 2'd2;

  localparam logic [POS_W-1:0] UNKNOWN_POS = 8'd255;
  localparam logic [DIR_W-1:0] MODE_UNKNOWN = 2'd0;
  localparam logic [MSF_W-1:0] MSF_RESET = 5'd8;

  localparam logic signed [COEF_W-1:0] DIAL_NUMBERS    = 12'sd100;
  localparam logic signed [COEF_W-1:0] FULL_TURN_STEPS = 12'sd200;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [TGT_W-1:0] target_position;
    logic [DIR_W-1:0] turn_direction;
  } cmd_t;

  typedef struct packed {
    logic signed [STEP_W-1:0] step_count;
    logic [MASK_W-1:0]        moved_mask;
    logic [POS_W-1:0]         dial_after;
  } res_t;

  typedef struct packed {
    logic [MSF_W-1:0] microstep_factor;
  } cfg_t;

  // Pickup request handed to the chain evaluator.
  typedef struct packed {
    logic [POS_W-1:0] target;
    logic [DIR_W-1:0] dir;
    logic             full;
    logic [POS_W-1:0] dial;
  } pick_req_t;

endpackage

`default_nettype wire

// ----- sv/cwpt_chan.sv -----
// ---------------------------------------------------------------------------
// cwpt_chan
// Valid/ready channel carrying one payload struct per beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface cwpt_chan #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- sv/cwpt_chain.sv -----
// ---------------------------------------------------------------------------
// cwpt_chain
// Wheel pickup decision along the chain, from the pre-command state.
// ---------------------------------------------------------------------------
`default_nettype none

module cwpt_chain #(
  parameter int WHEEL_COUNT = 3
) (
  input  cwpt_pkg::pick_req_t                                 req,
  input  logic [WHEEL_COUNT-1:0][cwpt_pkg::POS_W-1:0]         wheel_pos,
  input  logic [WHEEL_COUNT-1:0][cwpt_pkg::DIR_W-1:0]         wheel_mode,
  output logic [WHEEL_COUNT-1:0]                              moving
);
  import cwpt_pkg::*;

  logic [WHEEL_COUNT-1:0] pick;

  for (genvar w = 0; w < WHEEL_COUNT; w++) begin : g_wheel
    logic [POS_W-1:0] start;
    logic [DIR_W-1:0] drive_mode;
    logic [POS_W-1:0] p;
    logic             same;
    logic             cw;
    logic             ccw;

    if (w == 0) begin : g_dial
      assign start      = req.dial;
      assign drive_mode = req.dir;
    end else begin : g_wheel_drv
      assign start      = wheel_pos[w-1];
      assign drive_mode = wheel_mode[w-1];
    end

    assign p    = wheel_pos[w];
    assign cw   = (req.dir == DIR_CW);
    assign ccw  = (req.dir == DIR_CCW);
    assign same = (p == req.target) || ((p == start) && (wheel_mode[w] == req.dir));

    always_comb begin
      if (start < req.target) begin
        pick[w] = (ccw && (p > start) && (p < req.target))
               || (cw && ((p < start) || (p > req.target)))
               || same;
      end else if (start > req.target) begin
        pick[w] = (ccw && ((p > start) || (p < req.target)))
               || (cw && (p < start) && (p > req.target))
               || same;
      end else if (req.full) begin
        pick[w] = (drive_mode == req.dir);
      end else begin
        pick[w] = (wheel_mode[w] == req.dir);
      end
    end
  end

  // A wheel moves only if everything in front of it moves.
  always_comb begin
    moving[0] = pick[0];
    for (int w = 1; w < WHEEL_COUNT; w++) begin
      moving[w] = moving[w-1] && pick[w];
    end
  end

endmodule

`default_nettype wire

// ----- sv/combination_wheel_pack_tracker_top.sv -----
// ---------------------------------------------------------------------------
// combination_wheel_pack_tracker_top
// Dial and wheel chain tracker with stepper microstep output.
// ---------------------------------------------------------------------------
// Usage:
//   cmd  (sink)   : one command per beat: opcode, target_position,
//                   turn_direction.
//   res  (source) : one result per command: step_count, moved_mask,
//                   dial_after, in command order.
//   cfg  (sink)   : microstep_factor write; always ready. Write only while
//                   no command is in flight.
// Throughput: one command per cycle while res is not stalled. Commands land in
//   an input register; the pickup chain, the step multiply and the state update
//   run combinationally between that register and the result register.
// Reset (rst, synchronous): dial and wheel positions unknown (255), wheel
//   modes unknown, microstep_factor 8, both pipeline stages empty.
// Receiver stall: the result register holds; the input register still
//   accepts one more command, then cmd.ready drops until res drains.
// ---------------------------------------------------------------------------
`default_nettype none

module combination_wheel_pack_tracker_top #(
  parameter int WHEEL_COUNT = 3
) (
  input  logic      clk,
  input  logic      rst,
  cwpt_chan.sink    cmd,
  cwpt_chan.source  res,
  cwpt_chan.sink    cfg
);
  import cwpt_pkg::*;

  // architectural state
  logic [MSF_W-1:0]                   msf;
  logic [POS_W-1:0]                   dial_now;
  logic [POS_W-1:0]                   dial_now_next;
  logic [WHEEL_COUNT-1:0][POS_W-1:0]  wheel_pos;
  logic [WHEEL_COUNT-1:0][DIR_W-1:0]  wheel_mode;

  // pipeline
  logic  s1_valid;
  cmd_t  s1_cmd;
  logic  out_valid;
  res_t  out_res;
  res_t  out_res_next;
  logic  s1_adv;

  // datapath
  pick_req_t                  req;
  logic [WHEEL_COUNT-1:0]     moving;
  logic                       is_move;
  logic                       is_turn;
  logic                       is_zero;
  logic                       wheel_upd;
  logic [POS_W-1:0]           tgt_pos;
  logic signed [COEF_W-1:0]   cur_s;
  logic signed [COEF_W-1:0]   pos_s;
  logic signed [COEF_W-1:0]   coef;
  logic signed [MSF_W:0]      msf_s;
  logic signed [PROD_W-1:0]   prod;
  logic [MASK_W-1:0]          mask;

  assign s1_adv    = s1_valid && (!out_valid || res.ready);
  assign cmd.ready = !s1_valid || s1_adv;
  assign cfg.ready = 1'b1;

  assign res.valid   = out_valid;
  assign res.payload = out_res;

  always_comb begin
    is_move = 1'b0;
    is_turn = 1'b0;
    is_zero = 1'b0;
    unique case (s1_cmd.opcode)
      OP_MOVE: is_move = 1'b1;
      OP_TURN: is_turn = 1'b1;
      OP_ZERO: is_zero = 1'b1;
      default: ;
    endcase
  end

  assign tgt_pos    = POS_W'(s1_cmd.target_position);
  assign req.target = is_turn ? dial_now : tgt_pos;
  assign req.dir    = s1_cmd.turn_direction;
  assign req.full   = is_turn;
  assign req.dial   = dial_now;

  cwpt_chain #(
    .WHEEL_COUNT (WHEEL_COUNT)
  ) u_chain (
    .req        (req),
    .wheel_pos  (wheel_pos),
    .wheel_mode (wheel_mode),
    .moving     (moving)
  );

  assign wheel_upd = s1_adv && (is_move || is_turn);

  // Step coefficient: steps = coef * microstep_factor.
  assign cur_s = COEF_W'(dial_now);
  assign pos_s = COEF_W'(s1_cmd.target_position);

  always_comb begin
    coef = '0;
    if (is_move) begin
      if (req.dir == DIR_CW && cur_s > pos_s) begin
        coef = (cur_s - pos_s) <<< 1;
      end else if (req.dir == DIR_CW && cur_s < pos_s) begin
        coef = (cur_s + DIAL_NUMBERS - pos_s) <<< 1;
      end else if (req.dir == DIR_CCW && cur_s < pos_s) begin
        coef = (cur_s - pos_s) <<< 1;
      end else if (req.dir == DIR_CCW && cur_s > pos_s) begin
        coef = (cur_s - pos_s - DIAL_NUMBERS) <<< 1;
      end
    end else if (is_turn) begin
      coef = (req.dir == DIR_CW) ? FULL_TURN_STEPS : -FULL_TURN_STEPS;
    end
  end

  assign msf_s = $signed({1'b0, msf});
  assign prod  = coef * msf_s;

  for (genvar i = 0; i < MASK_W; i++) begin : g_mask
    if (i < WHEEL_COUNT) begin : g_bit
      assign mask[i] = (is_move || is_turn) && moving[i];
    end else begin : g_pad
      assign mask[i] = 1'b0;
    end
  end

  always_comb begin
    dial_now_next = dial_now;
    if (is_move) begin
      dial_now_next = tgt_pos;
    end else if (is_zero) begin
      dial_now_next = '0;
    end
  end

  always_comb begin
    out_res_next.step_count = prod[STEP_W-1:0];
    out_res_next.moved_mask = mask;
    out_res_next.dial_after = dial_now_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      msf <= MSF_RESET;
    end else if (cfg.valid && cfg.ready) begin
      msf <= cfg.payload.microstep_factor;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dial_now <= UNKNOWN_POS;
    end else if (s1_adv) begin
      dial_now <= dial_now_next;
    end
  end

  for (genvar w = 0; w < WHEEL_COUNT; w++) begin : g_state
    always_ff @(posedge clk) begin
      if (rst) begin
        wheel_pos[w]  <= UNKNOWN_POS;
        wheel_mode[w] <= MODE_UNKNOWN;
      end else if (wheel_upd && moving[w]) begin
        wheel_pos[w]  <= req.target;
        wheel_mode[w] <= req.dir;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s1_cmd <= cmd.payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res <= out_res_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/cwpt_checker.sv -----
// ---------------------------------------------------------------------------
// cwpt_checker
// Port-level checks on the tracker's result channel.
// ---------------------------------------------------------------------------
`default_nettype none

`include "combination_wheel_pack_tracker_top_assert.svh"

module cwpt_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           res_valid,
  input wire logic           res_ready,
  input wire cwpt_pkg::res_t res_payload
);

  // no result survives reset
  `CWPT_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !res_valid, "result valid after reset")

  `CWPT_ASSERT(a_hold_valid, clk, rst, res_valid && !res_ready |=> res_valid, "result dropped")

  `CWPT_ASSERT(a_hold_data, clk, rst, res_valid && !res_ready |=> $stable(res_payload), "result changed")

  // pickup is chained: a wheel moves only if the one before it moved
  `CWPT_ASSERT(a_chain_mask, clk, rst, res_valid |-> ((!res_payload.moved_mask[1] || res_payload.moved_mask[0]) && (!res_payload.moved_mask[2] || res_payload.moved_mask[1])), "mask not chained")

endmodule

bind combination_wheel_pack_tracker_top cwpt_checker u_cwpt_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .res_payload (res.payload)
);

`default_nettype wire
